FILE: src/tlb_translated_memory_access_core_assert.svh
`ifndef TLB_TRANSLATED_MEMORY_ACCESS_CORE_ASSERT_SVH
`define TLB_TRANSLATED_MEMORY_ACCESS_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TLBMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TLBMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tlbma_pkg.sv
`timescale 1ns / 1ps

package tlbma_pkg;

    localparam int TLB_SLOTS_DEF  = 64;
    localparam int PHYS_BYTES_DEF = 1048576;

    localparam logic [2:0] CMD_LD_B   = 3'd0;
    localparam logic [2:0] CMD_LD_H   = 3'd1;
    localparam logic [2:0] CMD_LD_W   = 3'd2;
    localparam logic [2:0] CMD_ST_B   = 3'd3;
    localparam logic [2:0] CMD_ST_H   = 3'd4;
    localparam logic [2:0] CMD_ST_W   = 3'd5;
    localparam logic [2:0] CMD_TLB_WR = 3'd6;
    localparam logic [2:0] CMD_TLB_RD = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISS_LD  = 3'd1;
    localparam logic [2:0] ST_MISS_ST  = 3'd2;
    localparam logic [2:0] ST_MISALIGN = 3'd3;
    localparam logic [2:0] ST_BEYOND   = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [5:0]  tlb_index;
        logic [31:0] entry_hi;
        logic [31:0] entry_lo;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  status;
        logic [31:0] bad_vaddr;
        logic [31:0] read_entry_hi;
        logic [31:0] read_entry_lo;
    } t_resp;

    typedef struct packed {
        logic [19:0] vpn;
        logic        glb;
        logic [7:0]  asid;
        logic [25:0] pfn;
        logic [2:0]  cc;
        logic        dirty;
        logic        valid;
    } t_tlb_entry;

    typedef struct packed {
        logic wr;
        logic cmp;
        logic rd_idx;
        logic rd_hit;
    } t_tlb_ctl;

    typedef struct packed {
        logic       we;
        logic       re;
        logic [3:0] be;
    } t_mem_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENC,
        S_XLT,
        S_MEM
    } t_state;

endpackage

FILE: src/tlbma_tlb.sv
`timescale 1ns / 1ps

module tlbma_tlb #(
    parameter int TLB_SLOTS = tlbma_pkg::TLB_SLOTS_DEF,
    parameter int IW        = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tlbma_pkg::t_tlb_ctl   i_ctl,
    input  logic [IW-1:0]         i_index,
    input  logic [19:0]           i_vpn,
    input  tlbma_pkg::t_tlb_entry i_entry,
    output logic                  o_hit,
    output tlbma_pkg::t_tlb_entry o_entry
);
    import tlbma_pkg::*;

    logic [19:0]          r_vpn [TLB_SLOTS];
    t_tlb_entry           r_mem [TLB_SLOTS];
    logic [TLB_SLOTS-1:0] r_tv;
    logic [TLB_SLOTS-1:0] r_wr;
    logic [TLB_SLOTS-1:0] r_match;
    t_tlb_entry           r_rdata;
    logic                 r_rd_wr;
    logic                 r_hit;
    logic [IW-1:0]        hit_idx;
    logic [IW-1:0]        rd_addr;

    // lowest matching slot wins
    always_comb begin
        hit_idx = '0;
        for (int i = TLB_SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_idx = IW'(i);
            end
        end
    end

    assign rd_addr = i_ctl.rd_hit ? hit_idx : i_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv  <= '0;
            r_wr  <= '0;
            r_hit <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_tv[i_index] <= i_entry.valid;
                r_wr[i_index] <= 1'b1;
            end
            if (i_ctl.rd_hit) begin
                r_hit <= |r_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_vpn[i_index] <= i_entry.vpn;
            r_mem[i_index] <= i_entry;
        end
        if (i_ctl.cmp) begin
            for (int i = 0; i < TLB_SLOTS; i++) begin
                r_match[i] <= r_tv[i] && (r_vpn[i] == i_vpn);
            end
        end
        if (i_ctl.rd_idx || i_ctl.rd_hit) begin
            r_rdata <= r_mem[rd_addr];
            r_rd_wr <= r_wr[rd_addr];
        end
    end

    // never-written slots read back as zero
    assign o_hit   = r_hit;
    assign o_entry = r_rd_wr ? r_rdata : '0;

endmodule

FILE: src/tlbma_mem.sv
`timescale 1ns / 1ps

module tlbma_mem #(
    parameter int MW = tlbma_pkg::PHYS_BYTES_DEF / 4,
    parameter int AW = $clog2(MW)
) (
    input  logic                i_clk,
    input  tlbma_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]       i_addr,
    input  logic [31:0]         i_wdata,
    output logic [31:0]         o_rdata
);
    import tlbma_pkg::*;

    logic [31:0] r_mem [MW];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            for (int l = 0; l < 4; l++) begin
                if (i_ctl.be[l]) begin
                    r_mem[i_addr][l*8 +: 8] <= i_wdata[l*8 +: 8];
                end
            end
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/tlb_translated_memory_access_core.sv
// An accepted request passes S_ENC, S_XLT and S_MEM; its result is registered in S_MEM.
// Requests are taken only in S_IDLE, one at a time, each through its steps: TLB match at acceptance,
// priority encode with the entry-memory read, physical-memory access, then the result load, in turn.
// A finished result waits in the output register; the next request enters meanwhile and
// holds in its last step while that result is still untaken.
// Reset clears the TLB valid and written flags at once; memory keeps its contents.
`timescale 1ns / 1ps
`include "tlb_translated_memory_access_core_assert.svh"

module tlb_translated_memory_access_core #(
    parameter int TLB_SLOTS  = tlbma_pkg::TLB_SLOTS_DEF,
    parameter int PHYS_BYTES = tlbma_pkg::PHYS_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tlbma_pkg::t_req  i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output tlbma_pkg::t_resp o_resp
);
    import tlbma_pkg::*;

    localparam int          IW       = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;
    localparam int          MW       = PHYS_BYTES / 4;
    localparam int          AW       = $clog2(MW);
    localparam logic [32:0] PHYS_LIM = 33'(PHYS_BYTES);
    localparam logic [6:0]  SLOT_LIM = 7'(TLB_SLOTS);

    localparam logic [1:0] SZ_B = 2'd0;
    localparam logic [1:0] SZ_H = 2'd1;
    localparam logic [1:0] SZ_W = 2'd2;

    t_state      r_state;
    t_state      n_state;
    t_req        r_req;
    logic        r_idx_ok;
    logic [2:0]  r_status;
    logic [1:0]  r_lane;
    t_resp       r_out;
    t_resp       n_out;
    logic        r_out_vld;
    logic        n_out_vld;

    logic        accept;
    logic        idx_ok;
    logic        out_load;
    t_tlb_ctl    tlb_ctl;
    t_tlb_entry  wr_entry;
    t_tlb_entry  rd_entry;
    logic        tlb_hit;
    t_mem_ctl    mem_ctl;
    logic [31:0] mem_wdata;
    logic [31:0] mem_rdata;

    logic        is_mem;
    logic        is_store;
    logic [1:0]  size;
    logic [2:0]  nbytes;
    logic [31:0] pa;
    logic        hit;
    logic        misalign;
    logic        over;
    logic [2:0]  status;
    logic [31:0] load_val;

    assign accept = i_valid && o_ready;
    assign idx_ok = {1'b0, i_req.tlb_index} < SLOT_LIM;

    always_comb begin
        wr_entry.vpn   = i_req.entry_hi[31:12];
        wr_entry.glb   = i_req.entry_hi[11];
        wr_entry.asid  = i_req.entry_hi[7:0];
        wr_entry.pfn   = i_req.entry_lo[31:6];
        wr_entry.cc    = i_req.entry_lo[5:3];
        wr_entry.dirty = i_req.entry_lo[2];
        wr_entry.valid = i_req.entry_lo[1];
    end

    // access decode and translation checks, used in S_XLT
    always_comb begin
        is_mem   = r_req.cmd < CMD_TLB_WR;
        is_store = (r_req.cmd == CMD_ST_B) || (r_req.cmd == CMD_ST_H)
                || (r_req.cmd == CMD_ST_W);
        case (r_req.cmd)
            CMD_LD_H, CMD_ST_H: size = SZ_H;
            CMD_LD_W, CMD_ST_W: size = SZ_W;
            default:            size = SZ_B;
        endcase
        case (size)
            SZ_H:    nbytes = 3'd2;
            SZ_W:    nbytes = 3'd4;
            default: nbytes = 3'd1;
        endcase
        if (r_req.address[31:30] == 2'b10) begin
            hit = 1'b1;
            pa  = {2'b00, r_req.address[29:0]};
        end else begin
            hit = tlb_hit;
            pa  = {rd_entry.pfn[19:0], r_req.address[11:0]};
        end
        case (size)
            SZ_H:    misalign = pa[0];
            SZ_W:    misalign = |pa[1:0];
            default: misalign = 1'b0;
        endcase
        over = ({1'b0, pa} + {30'd0, nbytes}) > PHYS_LIM;
        if (!hit) begin
            status = is_store ? ST_MISS_ST : ST_MISS_LD;
        end else if (misalign) begin
            status = ST_MISALIGN;
        end else if (over) begin
            status = ST_BEYOND;
        end else begin
            status = ST_OK;
        end
    end

    // big-endian lanes: byte 0 of a word sits in bits 31:24
    always_comb begin
        case (size)
            SZ_H: begin
                mem_wdata  = {2{r_req.write_data[15:0]}};
                mem_ctl.be = pa[1] ? 4'b0011 : 4'b1100;
            end
            SZ_W: begin
                mem_wdata  = r_req.write_data;
                mem_ctl.be = 4'b1111;
            end
            default: begin
                mem_wdata  = {4{r_req.write_data[7:0]}};
                mem_ctl.be = 4'b1000 >> pa[1:0];
            end
        endcase
        mem_ctl.we = (r_state == S_XLT) && is_mem && is_store && (status == ST_OK);
        mem_ctl.re = (r_state == S_XLT) && is_mem && !is_store && (status == ST_OK);
    end

    always_comb begin
        case (size)
            SZ_H: load_val = r_lane[1] ? {16'd0, mem_rdata[15:0]} : {16'd0, mem_rdata[31:16]};
            SZ_W: load_val = mem_rdata;
            default: begin
                case (r_lane)
                    2'd0:    load_val = {24'd0, mem_rdata[31:24]};
                    2'd1:    load_val = {24'd0, mem_rdata[23:16]};
                    2'd2:    load_val = {24'd0, mem_rdata[15:8]};
                    default: load_val = {24'd0, mem_rdata[7:0]};
                endcase
            end
        endcase
    end

    always_comb begin
        n_out = '0;
        if (is_mem) begin
            n_out.status = r_status;
            if (r_status != ST_OK) begin
                n_out.bad_vaddr = r_req.address;
            end else if (!is_store) begin
                n_out.read_data = load_val;
            end
        end else if ((r_req.cmd == CMD_TLB_RD) && r_idx_ok) begin
            n_out.read_entry_hi = {rd_entry.vpn, rd_entry.glb, 3'd0, rd_entry.asid};
            n_out.read_entry_lo = {rd_entry.pfn, rd_entry.cc, rd_entry.dirty,
                                   rd_entry.valid, 1'b0};
        end
    end

    // next state
    always_comb begin
        case (r_state)
            S_IDLE:  n_state = i_valid ? S_ENC : S_IDLE;
            S_ENC:   n_state = S_XLT;
            S_XLT:   n_state = S_MEM;
            S_MEM:   n_state = (!r_out_vld || i_ready) ? S_IDLE : S_MEM;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready        = (r_state == S_IDLE);
        tlb_ctl.wr     = accept && (i_req.cmd == CMD_TLB_WR) && idx_ok;
        tlb_ctl.cmp    = accept;
        tlb_ctl.rd_idx = accept && (i_req.cmd == CMD_TLB_RD) && idx_ok;
        tlb_ctl.rd_hit = (r_state == S_ENC) && is_mem;
        out_load       = (r_state == S_MEM) && (!r_out_vld || i_ready);
    end

    // hold the result until taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_req;
            r_idx_ok <= idx_ok;
        end
        if (r_state == S_XLT) begin
            r_status <= status;
            r_lane   <= pa[1:0];
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_resp  = r_out;

    tlbma_tlb #(
        .TLB_SLOTS (TLB_SLOTS),
        .IW        (IW)
    ) u_tlb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tlb_ctl),
        .i_index (i_req.tlb_index[IW-1:0]),
        .i_vpn   (i_req.address[31:12]),
        .i_entry (wr_entry),
        .o_hit   (tlb_hit),
        .o_entry (rd_entry)
    );

    tlbma_mem #(
        .MW (MW),
        .AW (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (pa[AW+1:2]),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    `TLBMA_ASSERT_NEXT(a_accept_to_enc, i_clk, i_rst_n, accept, r_state == S_ENC, "accepted request did not advance to encode")
    `TLBMA_ASSERT_NOW(a_fail_no_data, i_clk, i_rst_n, o_valid && (o_resp.status != ST_OK), o_resp.read_data == 32'd0, "failed access returned load data")
    `TLBMA_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, (r_state == S_MEM) && r_out_vld && !i_ready, (r_state == S_MEM) && o_valid, "result overwritten or dropped under stall")

endmodule

FILE: verif/tlb_translated_memory_access_core_tb.sv
`timescale 1ns / 1ps

module tlb_translated_memory_access_core_tb;
    import tlbma_pkg::*;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MOSTLY,
        RX_COIN,
        RX_CHOKE
    } t_rx_mode;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_req  i_req;
    logic  o_valid;
    logic  i_ready;
    t_resp o_resp;

    tlb_translated_memory_access_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_resp  (o_resp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow state of the block.
    t_tlb_entry  tlb_shadow [TLB_SLOTS_DEF];
    logic [7:0]  phys_bytes [logic [31:0]];

    t_resp       expected_resps [$];
    logic [31:0] stored_vas [$];
    logic [19:0] vpn_pool [8];
    int          burst_left = 0;
    int          mismatches = 0;

    // ---------------------------------------------------------------- prediction

    function automatic int unsigned access_bytes(input logic [2:0] cmd);
        case (cmd)
            CMD_LD_B, CMD_ST_B: return 1;
            CMD_LD_H, CMD_ST_H: return 2;
            default:            return 4;
        endcase
    endfunction

    function automatic bit translate_va(input logic [31:0] va, output logic [31:0] pa);
        pa = '0;
        if (va[31:30] == 2'b10) begin
            pa = va - 32'h8000_0000;
            return 1'b1;
        end
        // lowest matching valid slot wins; only pfn bits 19:0 survive the shift
        for (int i = 0; i < TLB_SLOTS_DEF; i++) begin
            if (tlb_shadow[i].valid && tlb_shadow[i].vpn == va[31:12]) begin
                pa = {tlb_shadow[i].pfn[19:0], va[11:0]};
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [2:0] access_status(input t_req r, output logic [31:0] pa);
        int unsigned nbytes;
        logic [32:0] span_end;
        nbytes = access_bytes(r.cmd);
        if (!translate_va(r.address, pa)) begin
            return (r.cmd >= CMD_ST_B) ? ST_MISS_ST : ST_MISS_LD;
        end
        if ((pa & (nbytes - 1)) != 0) begin
            return ST_MISALIGN;
        end
        span_end = {1'b0, pa} + 33'(nbytes);
        if (span_end > 33'(PHYS_BYTES_DEF)) begin
            return ST_BEYOND;
        end
        return ST_OK;
    endfunction

    function automatic t_resp execute_request(input t_req r);
        t_resp       rsp;
        t_tlb_entry  e;
        logic [31:0] pa;
        int unsigned nbytes;
        rsp = '0;
        case (r.cmd)
            CMD_TLB_WR: begin
                e.vpn   = r.entry_hi[31:12];
                e.glb   = r.entry_hi[11];
                e.asid  = r.entry_hi[7:0];
                e.pfn   = r.entry_lo[31:6];
                e.cc    = r.entry_lo[5:3];
                e.dirty = r.entry_lo[2];
                e.valid = r.entry_lo[1];
                tlb_shadow[r.tlb_index] = e;
            end
            CMD_TLB_RD: begin
                e = tlb_shadow[r.tlb_index];
                rsp.read_entry_hi = {e.vpn, e.glb, 3'b000, e.asid};
                rsp.read_entry_lo = {e.pfn, e.cc, e.dirty, e.valid, 1'b0};
            end
            default: begin
                nbytes = access_bytes(r.cmd);
                rsp.status = access_status(r, pa);
                if (rsp.status != ST_OK) begin
                    rsp.bad_vaddr = r.address;
                end else if (r.cmd >= CMD_ST_B) begin
                    for (int k = 0; k < nbytes; k++)
                        phys_bytes[pa + k] = 8'(r.write_data >> (8 * (nbytes - 1 - k)));
                end else begin
                    for (int k = 0; k < nbytes; k++)
                        rsp.read_data = {rsp.read_data[23:0], phys_bytes[pa + k]};
                end
            end
        endcase
        return rsp;
    endfunction

    function automatic bit reads_unwritten(input t_req r);
        logic [31:0] pa;
        if (r.cmd > CMD_LD_W) return 1'b0;
        if (access_status(r, pa) != ST_OK) return 1'b0;
        for (int k = 0; k < access_bytes(r.cmd); k++)
            if (!phys_bytes.exists(pa + k)) return 1'b1;
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic send_request(input t_req r);
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_resps.push_back(execute_request(r));
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40)
                                                      : $urandom_range(0, 6);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function automatic t_req make_req(input logic [2:0] cmd, input logic [31:0] addr,
                                      input logic [31:0] wdata, input logic [5:0] idx,
                                      input logic [31:0] hi, input logic [31:0] lo);
        t_req r;
        r.cmd        = cmd;
        r.address    = addr;
        r.write_data = wdata;
        r.tlb_index  = idx;
        r.entry_hi   = hi;
        r.entry_lo   = lo;
        return r;
    endfunction

    // Response side: stall in phases of its own, re-picked each time rx_tick[5:0] returns to zero.
    logic [7:0] rx_tick = '0;
    t_rx_mode   rx_mode = RX_OPEN;

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_tick[5:0] == 6'd0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   i_ready <= 1'b1;
            RX_MOSTLY: i_ready <= (rx_tick[1:0] != 2'd3);
            RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
            default:   i_ready <= (rx_tick[3:0] >= 4'd10);
        endcase
    end

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : resp_check
        t_resp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_resps.size() == 0) begin
                $display("%0t: unexpected response: expected none, actual %h", $time, o_resp);
                mismatches++;
            end else begin
                want = expected_resps.pop_front();
                check_field("read_data", want.read_data, o_resp.read_data);
                check_field("status", 32'(want.status), 32'(o_resp.status));
                check_field("bad_vaddr", want.bad_vaddr, o_resp.bad_vaddr);
                check_field("read_entry_hi", want.read_entry_hi, o_resp.read_entry_hi);
                check_field("read_entry_lo", want.read_entry_lo, o_resp.read_entry_lo);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_tlb_entry_fields();
        send_request(make_req(CMD_TLB_RD, '0, '0, 6'd0, '0, '0));
        send_request(make_req(CMD_TLB_WR, '0, '0, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_req(CMD_TLB_RD, '0, '0, 6'd63, '0, '0));
        // bits 10:8 of hi and bit 0 of lo are dropped; pfn bit 25 is kept but not mapped
        send_request(make_req(CMD_TLB_WR, '0, '0, 6'd2, 32'h7FFF_F7A5,
                              {26'h20000FF, 3'b101, 1'b0, 1'b1, 1'b1}));
        send_request(make_req(CMD_TLB_RD, '0, '0, 6'd2, '0, '0));
    endtask

    task automatic test_translation_and_endianness();
        send_request(make_req(CMD_TLB_WR, '0, '0, 6'd0, 32'h0000_185A,
                              {26'd2, 3'b011, 1'b1, 1'b1, 1'b0}));
        // same page in a higher slot must lose to slot 0
        send_request(make_req(CMD_TLB_WR, '0, '0, 6'd1, 32'h0000_1000,
                              {26'd7, 3'b000, 1'b0, 1'b1, 1'b0}));
        send_request(make_req(CMD_ST_W, 32'h0000_1010, 32'hDEAD_BEEF, '0, '0, '0));
        send_request(make_req(CMD_LD_W, 32'h0000_1010, '0, '0, '0, '0));
        send_request(make_req(CMD_LD_B, 32'h0000_1013, '0, '0, '0, '0));
        send_request(make_req(CMD_LD_H, 32'h0000_1012, '0, '0, '0, '0));
        // direct map onto the same physical word
        send_request(make_req(CMD_ST_B, 32'h8000_2011, 32'hFFFF_FF00, '0, '0, '0));
        send_request(make_req(CMD_LD_W, 32'h0000_1010, '0, '0, '0, '0));
        // half ending exactly at the top of memory, then read back via direct map
        send_request(make_req(CMD_ST_H, 32'h7FFF_FFFE, 32'h1234_ABCD, '0, '0, '0));
        send_request(make_req(CMD_LD_H, 32'h800F_FFFE, '0, '0, '0, '0));
        send_request(make_req(CMD_ST_W, 32'h800F_FFFC, 32'hFFFF_FFFF, '0, '0, '0));
        send_request(make_req(CMD_LD_B, 32'h800F_FFFF, '0, '0, '0, '0));
    endtask

    task automatic test_fault_ordering();
        send_request(make_req(CMD_TLB_WR, '0, '0, 6'd3, 32'hC000_0000,
                              {26'd3, 3'b000, 1'b1, 1'b0, 1'b0}));
        send_request(make_req(CMD_LD_W, 32'hC000_0000, '0, '0, '0, '0));
        send_request(make_req(CMD_LD_W, 32'h8010_0000, '0, '0, '0, '0));
        send_request(make_req(CMD_ST_B, 32'hBFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0));
        send_request(make_req(CMD_LD_H, 32'h8000_0001, '0, '0, '0, '0));
        send_request(make_req(CMD_ST_W, 32'h0000_1012, 32'h5555_AAAA, '0, '0, '0));
        send_request(make_req(CMD_ST_W, 32'hFFFF_F004, 32'h0F0F_0F0F, '0, '0, '0));
        // miss is reported ahead of misalignment
        send_request(make_req(CMD_ST_H, 32'h0000_0003, 32'h0000_FFFF, '0, '0, '0));
    endtask

    function automatic logic [19:0] pick_vpn();
        return ($urandom_range(0, 7) != 0) ? vpn_pool[$urandom_range(0, 7)]
                                           : 20'($urandom);
    endfunction

    function automatic logic [25:0] pick_pfn();
        case ($urandom_range(0, 9))
            0:       return 26'($urandom);
            1:       return 26'h00000FF;
            // bits 25:20 never reach the physical address
            default: return {6'($urandom), 20'($urandom_range(0, 15))};
        endcase
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int unsigned pick;
        int unsigned sel;
        int unsigned nbytes;
        bit          is_store;
        r.cmd        = 3'($urandom);
        r.address    = $urandom;
        r.write_data = $urandom;
        r.tlb_index  = 6'($urandom);
        r.entry_hi   = $urandom;
        r.entry_lo   = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            r.cmd = CMD_TLB_WR;
            if ($urandom_range(0, 3) != 0) r.tlb_index = 6'($urandom_range(0, 15));
            if ($urandom_range(0, 9) != 0) begin
                r.entry_hi[31:12] = pick_vpn();
                r.entry_lo[31:6]  = pick_pfn();
                r.entry_lo[1]     = ($urandom_range(0, 6) != 0);
            end
            return r;
        end
        if (pick < 13) begin
            r.cmd = CMD_TLB_RD;
            return r;
        end
        is_store = (pick < 53);
        case ($urandom_range(0, 2))
            0:       r.cmd = is_store ? CMD_ST_B : CMD_LD_B;
            1:       r.cmd = is_store ? CMD_ST_H : CMD_LD_H;
            default: r.cmd = is_store ? CMD_ST_W : CMD_LD_W;
        endcase
        nbytes = access_bytes(r.cmd);
        sel = $urandom_range(0, 9);
        if (!is_store && stored_vas.size() != 0 && $urandom_range(0, 1) == 1) begin
            r.address = stored_vas[$urandom_range(0, stored_vas.size() - 1)];
        end else if (sel < 4) begin
            r.address = 32'h8000_0000 + $urandom_range(0, 32'hFFFF);
        end else if (sel < 8) begin
            r.address = {pick_vpn(), 12'($urandom)};
        end else if (sel == 8) begin
            r.address = 32'h800F_FFF0 + $urandom_range(0, 31);
        end
        if ($urandom_range(0, 4) != 0) r.address = r.address & ~(nbytes - 1);
        if (is_store) begin
            stored_vas.push_back(r.address);
            if (stored_vas.size() > 32) void'(stored_vas.pop_front());
        end
        // turn a load of never-written bytes into a store of the same span
        if (reads_unwritten(r)) r.cmd = r.cmd + (CMD_ST_B - CMD_LD_B);
        return r;
    endfunction

    task automatic test_random_traffic(input int n_items);
        vpn_pool = '{20'h00000, 20'h00001, 20'h7FFFF, 20'h80000,
                     20'hC0000, 20'hFFFFF, 20'($urandom), 20'($urandom)};
        for (int n = 0; n < n_items; n++) send_request(random_request());
    endtask

    // ---------------------------------------------------------------- run

    initial begin
        for (int i = 0; i < TLB_SLOTS_DEF; i++) tlb_shadow[i] = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        i_ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_tlb_entry_fields();
        test_translation_and_endianness();
        test_fault_ordering();
        test_random_traffic(850);

        i_valid <= 1'b0;
        while (expected_resps.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

endmodule
